/* sv/srev_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the segment reversal engine.
package srev_pkg;

    localparam int OpW  = 2;
    localparam int PosW = 17;
    localparam int ValW = 17;
    localparam int StW  = 2;

    localparam logic [OpW-1:0] OP_START  = 2'd0;
    localparam logic [OpW-1:0] OP_RECORD = 2'd1;
    localparam logic [OpW-1:0] OP_QUERY  = 2'd2;

    localparam logic [StW-1:0] ST_OK    = 2'd0;
    localparam logic [StW-1:0] ST_RANGE = 2'd1;
    localparam logic [StW-1:0] ST_FULL  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_AP_RD,
        S_AP_RNG,
        S_SW_RD0,
        S_SW_RD1,
        S_SW_WR0,
        S_SW_WR1,
        S_QRD,
        S_QOUT
    } t_state;

endpackage

/* sv/srev_ram.sv */
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM: one write port, one registered read port.
module srev_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AddrW-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/srev_ctrl.sv */
`timescale 1ns / 1ps
// Command decode, fill/apply/query sequencer and result register.
module srev_ctrl
    import srev_pkg::*;
#(
    parameter int MAX_GENES     = 65536,
    parameter int MAX_REVERSALS = 1024,
    localparam int GeneAw = $clog2(MAX_GENES),
    localparam int RevAw  = (MAX_REVERSALS > 1) ? $clog2(MAX_REVERSALS) : 1,
    localparam int RevW   = 2 * GeneAw
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [OpW-1:0]    i_opcode,
    input  logic [PosW-1:0]   i_first_pos,
    input  logic [PosW-1:0]   i_last_pos,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [ValW-1:0]   o_gene_value,
    output logic [StW-1:0]    o_status,
    output logic              o_seq_we,
    output logic [GeneAw-1:0] o_seq_waddr,
    output logic [ValW-1:0]   o_seq_wdata,
    output logic              o_seq_re,
    output logic [GeneAw-1:0] o_seq_raddr,
    input  logic [ValW-1:0]   i_seq_rdata,
    output logic              o_rev_we,
    output logic [RevAw-1:0]  o_rev_waddr,
    output logic [RevW-1:0]   o_rev_wdata,
    output logic              o_rev_re,
    output logic [RevAw-1:0]  o_rev_raddr,
    input  logic [RevW-1:0]   i_rev_rdata
);

    localparam int CntW = $clog2(MAX_REVERSALS + 1);
    localparam logic [PosW-1:0] MaxLen = PosW'(MAX_GENES);
    localparam logic [CntW-1:0] MaxRev = CntW'(MAX_REVERSALS);

    t_state r_state, n_state;

    logic [PosW-1:0]   r_len;
    logic [CntW-1:0]   r_count;
    logic              r_pending;
    logic [CntW-1:0]   r_k;
    logic [GeneAw-1:0] r_fill;
    logic [GeneAw-1:0] r_lo;
    logic [GeneAw-1:0] r_hi;
    logic [ValW-1:0]   r_tmp;
    logic [GeneAw-1:0] r_qaddr;
    logic              r_out_valid;
    logic [ValW-1:0]   r_gene_value;
    logic [StW-1:0]    r_status;

    logic              out_free;
    logic              in_acc;
    logic              a_ok;
    logic              b_ok;
    logic              d_start_ok;
    logic              d_rec_ok;
    logic              d_qry_ok;
    logic [StW-1:0]    d_status;
    logic [PosW-1:0]   a_m1;
    logic [PosW-1:0]   b_m1;
    logic [PosW-1:0]   len_m1;
    logic              fill_last;
    logic              swap_go;
    logic [CntW-1:0]   k_m1;

    function automatic logic pos_ok(input logic [PosW-1:0] p, input logic [PosW-1:0] len);
        pos_ok = (p != '0) && (p <= len);
    endfunction

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign a_ok      = pos_ok(i_first_pos, r_len);
    assign b_ok      = pos_ok(i_last_pos, r_len);
    assign a_m1      = i_first_pos - PosW'(1);
    assign b_m1      = i_last_pos - PosW'(1);
    assign len_m1    = r_len - PosW'(1);
    assign fill_last = (r_fill == len_m1[GeneAw-1:0]);
    assign swap_go   = (r_lo < r_hi);
    assign k_m1      = r_k - CntW'(1);

    // Decode the item at the input.
    always_comb begin
        d_start_ok = 1'b0;
        d_rec_ok   = 1'b0;
        d_qry_ok   = 1'b0;
        d_status   = ST_OK;
        unique case (i_opcode)
            OP_START: begin
                if ((i_last_pos == '0) || (i_last_pos > MaxLen)) begin
                    d_status = ST_RANGE;
                end else begin
                    d_start_ok = 1'b1;
                end
            end
            OP_RECORD: begin
                if (!a_ok || !b_ok) begin
                    d_status = ST_RANGE;
                end else if (r_count >= MaxRev) begin
                    d_status = ST_FULL;
                end else begin
                    d_rec_ok = 1'b1;
                end
            end
            OP_QUERY: begin
                if (!a_ok) begin
                    d_status = ST_RANGE;
                end else begin
                    d_qry_ok = 1'b1;
                end
            end
            default: begin
                d_status = ST_RANGE;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && d_start_ok) begin
                    n_state = S_FILL;
                end else if (in_acc && d_qry_ok) begin
                    n_state = r_pending ? S_AP_RD : S_QOUT;
                end
            end
            S_FILL: begin
                if (fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_AP_RD:  n_state = S_AP_RNG;
            S_AP_RNG: n_state = S_SW_RD0;
            S_SW_RD0: begin
                if (swap_go) begin
                    n_state = S_SW_RD1;
                end else if (r_k == '0) begin
                    n_state = S_QRD;
                end else begin
                    n_state = S_AP_RD;
                end
            end
            S_SW_RD1: n_state = S_SW_WR0;
            S_SW_WR0: n_state = S_SW_WR1;
            S_SW_WR1: n_state = S_SW_RD0;
            S_QRD:    n_state = S_QOUT;
            S_QOUT:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Memory port controls.
    always_comb begin
        o_seq_we    = 1'b0;
        o_seq_waddr = r_fill;
        o_seq_wdata = ValW'(r_fill) + ValW'(1);
        o_seq_re    = 1'b0;
        o_seq_raddr = a_m1[GeneAw-1:0];
        o_rev_we    = 1'b0;
        o_rev_waddr = r_count[RevAw-1:0];
        o_rev_wdata = {a_m1[GeneAw-1:0], b_m1[GeneAw-1:0]};
        o_rev_re    = 1'b0;
        o_rev_raddr = k_m1[RevAw-1:0];
        unique case (r_state)
            S_IDLE: begin
                o_seq_re = in_acc;
                o_rev_we = in_acc && d_rec_ok;
            end
            S_FILL: begin
                o_seq_we = 1'b1;
            end
            S_AP_RD: begin
                o_rev_re = 1'b1;
            end
            S_SW_RD0: begin
                o_seq_re    = swap_go;
                o_seq_raddr = r_lo;
            end
            S_SW_RD1: begin
                o_seq_re    = 1'b1;
                o_seq_raddr = r_hi;
            end
            S_SW_WR0: begin
                o_seq_we    = 1'b1;
                o_seq_waddr = r_lo;
                o_seq_wdata = i_seq_rdata;
            end
            S_SW_WR1: begin
                o_seq_we    = 1'b1;
                o_seq_waddr = r_hi;
                o_seq_wdata = r_tmp;
            end
            S_QRD: begin
                o_seq_re    = 1'b1;
                o_seq_raddr = r_qaddr;
            end
            default: begin
                o_seq_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_count     <= '0;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((in_acc && !d_qry_ok) || (r_state == S_QOUT)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                if (d_start_ok) begin
                    r_len     <= i_last_pos;
                    r_count   <= '0;
                    r_pending <= 1'b0;
                end
                if (d_rec_ok) begin
                    r_count   <= r_count + CntW'(1);
                    r_pending <= 1'b1;
                end
            end
            if (r_state == S_QRD) begin
                r_count   <= '0;
                r_pending <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_gene_value <= '0;
            r_status     <= d_status;
            r_fill       <= '0;
            r_qaddr      <= a_m1[GeneAw-1:0];
            r_k          <= r_count;
        end
        if (r_state == S_FILL) begin
            r_fill <= r_fill + GeneAw'(1);
        end
        if (r_state == S_AP_RD) begin
            r_k <= k_m1;
        end
        if (r_state == S_AP_RNG) begin
            r_lo <= i_rev_rdata[RevW-1:GeneAw];
            r_hi <= i_rev_rdata[GeneAw-1:0];
        end
        if (r_state == S_SW_RD1) begin
            r_tmp <= i_seq_rdata;
        end
        if (r_state == S_SW_WR1) begin
            r_lo <= r_lo + GeneAw'(1);
            r_hi <= r_hi - GeneAw'(1);
        end
        if (r_state == S_QOUT) begin
            r_gene_value <= i_seq_rdata;
            r_status     <= ST_OK;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_gene_value = r_gene_value;
    assign o_status     = r_status;

    // The query result always finds the result register empty.
    a_qout_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QOUT) |-> !r_out_valid)
        else $error("query result would overwrite a pending result");

    // Fill never runs past the sequence length.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (PosW'(r_fill) < r_len))
        else $error("fill address beyond sequence length");

    // A swap only starts on a range that still has two distinct ends.
    a_swap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SW_RD1) |-> (r_lo < r_hi))
        else $error("swap with crossed ends");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MaxRev)
        else $error("reversal count above list depth");

    // Apply pass starts only with stored ranges.
    a_apply_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && n_state == S_AP_RD) |-> (r_count != '0))
        else $error("apply pass with empty list");

endmodule

/* sv/segment_reversal_engine.sv */
`timescale 1ns / 1ps
// Top level: segment reversal engine over a sequence memory and a range list.
//
//   channel | direction | handshake              | payload
//   input   | in        | i_in_valid / o_in_stall | i_opcode, i_first_pos, i_last_pos
//   output  | out       | o_out_valid / i_out_stall | o_gene_value, o_status
//
// Record, error and start items need no memory pass; a start then fills n entries,
// 1 a cycle. A query reads the sequence RAM through its registered read port; a query
// after records runs the apply pass after its accept cycle: per range a list read and
// per swap two reads and two writes on the single-write RAM port, then the query read.
// Reset clears control only; both RAMs hold garbage until written, no clearing pass.
// The next transfer is taken only when the result register is empty or draining.
module segment_reversal_engine
    import srev_pkg::*;
#(
    parameter int MAX_GENES     = 65536,
    parameter int MAX_REVERSALS = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [OpW-1:0]  i_opcode,
    input  logic [PosW-1:0] i_first_pos,
    input  logic [PosW-1:0] i_last_pos,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [ValW-1:0] o_gene_value,
    output logic [StW-1:0]  o_status
);

    localparam int GeneAw = $clog2(MAX_GENES);
    localparam int RevAw  = (MAX_REVERSALS > 1) ? $clog2(MAX_REVERSALS) : 1;
    localparam int RevW   = 2 * GeneAw;

    logic              seq_we;
    logic [GeneAw-1:0] seq_waddr;
    logic [ValW-1:0]   seq_wdata;
    logic              seq_re;
    logic [GeneAw-1:0] seq_raddr;
    logic [ValW-1:0]   seq_rdata;
    logic              rev_we;
    logic [RevAw-1:0]  rev_waddr;
    logic [RevW-1:0]   rev_wdata;
    logic              rev_re;
    logic [RevAw-1:0]  rev_raddr;
    logic [RevW-1:0]   rev_rdata;

    srev_ctrl #(
        .MAX_GENES     (MAX_GENES),
        .MAX_REVERSALS (MAX_REVERSALS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_first_pos  (i_first_pos),
        .i_last_pos   (i_last_pos),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_gene_value (o_gene_value),
        .o_status     (o_status),
        .o_seq_we     (seq_we),
        .o_seq_waddr  (seq_waddr),
        .o_seq_wdata  (seq_wdata),
        .o_seq_re     (seq_re),
        .o_seq_raddr  (seq_raddr),
        .i_seq_rdata  (seq_rdata),
        .o_rev_we     (rev_we),
        .o_rev_waddr  (rev_waddr),
        .o_rev_wdata  (rev_wdata),
        .o_rev_re     (rev_re),
        .o_rev_raddr  (rev_raddr),
        .i_rev_rdata  (rev_rdata)
    );

    srev_ram #(
        .WIDTH (ValW),
        .DEPTH (MAX_GENES)
    ) u_seq_ram (
        .i_clk   (i_clk),
        .i_we    (seq_we),
        .i_waddr (seq_waddr),
        .i_wdata (seq_wdata),
        .i_re    (seq_re),
        .i_raddr (seq_raddr),
        .o_rdata (seq_rdata)
    );

    srev_ram #(
        .WIDTH (RevW),
        .DEPTH (MAX_REVERSALS)
    ) u_rev_ram (
        .i_clk   (i_clk),
        .i_we    (rev_we),
        .i_waddr (rev_waddr),
        .i_wdata (rev_wdata),
        .i_re    (rev_re),
        .i_raddr (rev_raddr),
        .o_rdata (rev_rdata)
    );

endmodule
